FILE: src/pidaw_pkg.sv
package pidaw_pkg;

   localparam int ValueWidth = 32;
   localparam logic signed [31:0] ValueMax = 32'sh7fffffff;
   localparam logic signed [31:0] ValueMin = 32'sh80000000;
   localparam logic signed [31:0] PiRaw = 32'sd205887;
   localparam logic signed [31:0] HalfTurnDegRaw = 32'sd11796480;
   localparam logic [30:0] TiThresholdRaw = 31'd6;

   // csr indexes
   localparam logic [2:0] CsrKp = 3'd0;
   localparam logic [2:0] CsrTi = 3'd1;
   localparam logic [2:0] CsrTd = 3'd2;
   localparam logic [2:0] CsrTrim = 3'd3;
   localparam logic [2:0] CsrMin = 3'd4;
   localparam logic [2:0] CsrMax = 3'd5;
   localparam logic [2:0] CsrWrap = 3'd6;

   localparam logic [1:0] WrapDeg = 2'd1;
   localparam logic [1:0] WrapRad = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE, ST_ERR, ST_WRAP, ST_PTERM, ST_IMUL, ST_IDIV, ST_IACC,
      ST_DMUL, ST_DDIV, ST_SUM, ST_CLAMP, ST_DONE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic err;
      logic wrap;
      logic pterm;
      logic imul;
      logic idiv_start;
      logic iacc;
      logic dmul;
      logic ddiv_start;
      logic sum;
      logic clamp;
   } cmd_type;

   typedef struct packed {
      logic div_done;
   } status_type;

   // saturate a 66-bit signed value to 32 bits
   function automatic logic signed [31:0] sat66(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) r = ValueMax;
      else if (v < -66'sd2147483648) r = ValueMin;
      else r = v[31:0];
      return r;
   endfunction

endpackage

FILE: src/pid_antiwindup_controller_unit.sv
// one tick is processed at a time, and each tick runs two serial divides
// the next request is taken the cycle after the response beat has been delivered
// reset: synchronous, clears integral and previous measurement, arms restart,
// and loads the clamp registers with the full signed range
module pid_antiwindup_controller_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [31:0] req_measurement,
   input  logic signed [31:0] req_setpoint,
   input  logic [30:0]        req_time_step,
   input  logic               req_enable,
   input  logic               req_restart_request,
   input  logic signed [31:0] req_actuator_now,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_drive,
   output logic               rsp_drive_written,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import pidaw_pkg::*;

   cmd_type cmd;
   status_type status;

   pidaw_control u_control (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .status(status), .cmd(cmd)
   );

   pidaw_datapath u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .status(status),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data),
      .req_measurement(req_measurement), .req_setpoint(req_setpoint),
      .req_time_step(req_time_step), .req_enable(req_enable),
      .req_restart_request(req_restart_request),
      .req_actuator_now(req_actuator_now),
      .drive(rsp_drive), .drive_written(rsp_drive_written)
   );

endmodule

FILE: src/pidaw_div.sv
module pidaw_div (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  dividend,
   input  logic [30:0]         divisor,
   output logic                done,
   output logic signed [63:0]  quotient
);
   import pidaw_pkg::*;

   logic [63:0] quot_ff, quot_in;
   logic [31:0] rem_ff, rem_in;
   logic [30:0] dsr_ff, dsr_in;
   logic        neg_ff, neg_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [31:0] trial;

   // restoring divide, one quotient bit per cycle, truncates toward zero
   always_comb begin
      quot_in = quot_ff;
      rem_in = rem_ff;
      dsr_in = dsr_ff;
      neg_in = neg_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {rem_ff[30:0], quot_ff[63]};
      if (start) begin
         neg_in = dividend[63];
         quot_in = dividend[63] ? 64'(-dividend) : 64'(dividend);
         rem_in = '0;
         dsr_in = divisor;
         cnt_in = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dsr_ff}) begin
            rem_in = trial - {1'b0, dsr_ff};
            quot_in = {quot_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quot_in = {quot_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      neg_ff <= neg_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done = done_ff;
   assign quotient = neg_ff ? -$signed(quot_ff) : $signed(quot_ff);

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_busy_count: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != 7'd0) else $error("busy with zero count");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff) else $error("divider did not start");

endmodule

FILE: src/pidaw_datapath.sv
module pidaw_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  pidaw_pkg::cmd_type        cmd,
   output pidaw_pkg::status_type     status,
   input  logic                      csr_write,
   input  logic [2:0]                csr_index,
   input  logic [31:0]               csr_data,
   input  logic signed [31:0]        req_measurement,
   input  logic signed [31:0]        req_setpoint,
   input  logic [30:0]               req_time_step,
   input  logic                      req_enable,
   input  logic                      req_restart_request,
   input  logic signed [31:0]        req_actuator_now,
   output logic signed [31:0]        drive,
   output logic                      drive_written
);
   import pidaw_pkg::*;

   logic signed [31:0] kp_ff, trim_ff, omin_ff, omax_ff;
   logic [30:0] ti_ff, td_ff;
   logic [1:0] wrap_ff;
   logic signed [31:0] integ_ff, integ_in, prev_ff;
   logic pend_ff, pend_in;
   logic signed [31:0] y_ff, r_ff, act_ff, err_ff, err_in, pterm_ff, ke_ff, kd_ff;
   logic signed [31:0] dterm_ff, out_ff, out_in, dyn_ff;
   logic [30:0] dt_ff;
   logic en_ff;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [63:0] div_dividend;
   logic [30:0] div_divisor;
   logic signed [63:0] quot;
   logic div_start;
   logic integ_on;
   logic signed [31:0] u, base, m_a, m_b;
   logic signed [31:0] wrap_v;

   assign integ_on = ti_ff > TiThresholdRaw;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff <= '0; ti_ff <= '0; td_ff <= '0; trim_ff <= '0;
         omin_ff <= ValueMin; omax_ff <= ValueMax; wrap_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrKp: kp_ff <= csr_data;
            CsrTi: ti_ff <= csr_data[30:0];
            CsrTd: td_ff <= csr_data[30:0];
            CsrTrim: trim_ff <= csr_data;
            CsrMin: omin_ff <= csr_data;
            CsrMax: omax_ff <= csr_data;
            CsrWrap: wrap_ff <= csr_data[1:0];
            default: ;
         endcase
      end
   end

   // shared multiplier operands
   always_comb begin
      m_a = kp_ff;
      m_b = err_ff;
      if (cmd.dmul) m_b = $signed({1'b0, td_ff});
      prod_in = m_a * m_b;
   end

   // error and wrap
   always_comb begin
      err_in = err_ff;
      wrap_v = err_ff;
      if (cmd.err) err_in = sat66(66'(r_ff) - 66'(y_ff));
      else if (cmd.wrap) begin
         if (wrap_ff == WrapDeg) begin
            if (wrap_v < -HalfTurnDegRaw) wrap_v = sat66(66'(wrap_v) + 66'(2 * HalfTurnDegRaw));
            if (wrap_v > HalfTurnDegRaw) wrap_v = sat66(66'(wrap_v) - 66'(2 * HalfTurnDegRaw));
         end else if (wrap_ff == WrapRad) begin
            if (wrap_v < -PiRaw) wrap_v = sat66(66'(wrap_v) + 66'(2 * PiRaw));
            if (wrap_v > PiRaw) wrap_v = sat66(66'(wrap_v) - 66'(2 * PiRaw));
         end
         err_in = wrap_v;
      end
   end

   assign div_start = cmd.idiv_start | cmd.ddiv_start;
   assign div_dividend = cmd.idiv_start ? 64'(ke_ff) * $signed({33'd0, dt_ff})
                                        : 64'(kd_ff) * 64'(dyn_ff);
   assign div_divisor = cmd.idiv_start ? ti_ff : dt_ff;

   pidaw_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .dividend(div_dividend),
      .divisor(div_divisor), .done(status.div_done), .quotient(quot)
   );

   // integral, restart and output clamp
   always_comb begin
      integ_in = integ_ff;
      pend_in = pend_ff;
      out_in = out_ff;
      u = act_ff;
      base = out_ff;
      if (cmd.load && req_restart_request) pend_in = 1'b1;
      if (cmd.iacc) begin
         if (integ_on) integ_in = sat66(66'(integ_ff) + 66'(sat66(66'(quot))));
         else integ_in = '0;
         if (pend_ff) begin
            if (u < omin_ff) u = omin_ff;
            if (u > omax_ff) u = omax_ff;
            integ_in = integ_on ? sat66(66'(u) - 66'(pterm_ff)) : 32'sd0;
            pend_in = 1'b0;
         end
      end
      if (cmd.sum)
         out_in = sat66(66'(pterm_ff) + 66'(integ_ff) + 66'(dterm_ff));
      if (cmd.clamp) begin
         integ_in = integ_ff;
         if (base < omin_ff) begin
            if (integ_on) integ_in = sat66(66'(integ_in) + (66'(omin_ff) - 66'(base)));
            base = omin_ff;
         end
         if (base > omax_ff) begin
            if (integ_on) integ_in = sat66(66'(integ_in) - (66'(base) - 66'(omax_ff)));
            base = omax_ff;
         end
         out_in = base;
         if (!en_ff) pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      err_ff <= err_in;
      out_ff <= out_in;
      if (cmd.load) begin
         y_ff <= req_measurement;
         r_ff <= req_setpoint;
         dt_ff <= (req_time_step == '0) ? 31'd1 : req_time_step;
         en_ff <= req_enable;
         act_ff <= req_actuator_now;
         dyn_ff <= sat66(-66'(sat66(66'(req_measurement) - 66'(prev_ff))));
      end
      if (cmd.pterm) begin
         ke_ff <= sat66(66'(prod_ff >>> 16));
         pterm_ff <= sat66(66'(sat66(66'(prod_ff >>> 16))) + 66'(trim_ff));
      end
      if (cmd.dmul) kd_ff <= sat66(66'(prod_in >>> 16));
      if (cmd.ddiv_start) prev_ff <= y_ff;
      if (status.div_done && !cmd.iacc) dterm_ff <= sat66(66'(quot));
      if (reset) begin
         integ_ff <= '0;
         prev_ff <= '0;
         pend_ff <= 1'b1;
      end else begin
         integ_ff <= integ_in;
         pend_ff <= pend_in;
      end
   end

   assign drive = out_ff;
   assign drive_written = en_ff;

endmodule

FILE: src/pidaw_control.sv
module pidaw_control (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   input  pidaw_pkg::status_type  status,
   output pidaw_pkg::cmd_type     cmd
);
   import pidaw_pkg::*;

   state_type state_ff, state_in;
   logic out_ff, out_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // sequence one tick through the datapath
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      unique case (state_ff)
         ST_IDLE: if (req_valid && !out_ff) begin
            cmd.load = 1'b1;
            state_in = ST_ERR;
         end
         ST_ERR: begin cmd.err = 1'b1; state_in = ST_WRAP; end
         ST_WRAP: begin cmd.wrap = 1'b1; state_in = ST_PTERM; end
         ST_PTERM: begin state_in = ST_IMUL; end
         ST_IMUL: begin cmd.pterm = 1'b1; state_in = ST_IDIV; end
         ST_IDIV: begin cmd.idiv_start = 1'b1; state_in = ST_IACC; end
         ST_IACC: if (status.div_done) begin
            cmd.iacc = 1'b1;
            state_in = ST_DMUL;
         end
         ST_DMUL: begin cmd.dmul = 1'b1; state_in = ST_DDIV; end
         ST_DDIV: begin cmd.ddiv_start = 1'b1; state_in = ST_SUM; end
         ST_SUM: if (status.div_done) state_in = ST_CLAMP;
         ST_CLAMP: begin cmd.sum = 1'b1; state_in = ST_DONE; end
         ST_DONE: begin
            cmd.clamp = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // result register handshake
   always_comb begin
      out_in = out_ff;
      if (out_ff && !rsp_stall) out_in = 1'b0;
      if (state_ff == ST_DONE) out_in = 1'b1;
   end
   always_ff @(posedge clock) begin
      if (reset) out_ff <= 1'b0;
      else out_ff <= out_in;
   end

   assign rsp_valid = out_ff;
   assign req_stall = (state_ff != ST_IDLE) || out_ff;

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0(cmd)) else $error("more than one command");
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !out_ff) else $error("load while result pending");
   a_done_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |=> out_ff) else $error("result not raised");

endmodule

FILE: sim/pid_antiwindup_checker.sv
module pid_antiwindup_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_measurement,
   input  logic signed [31:0] req_setpoint,
   input  logic [30:0]        req_time_step,
   input  logic               req_enable,
   input  logic               req_restart_request,
   input  logic signed [31:0] req_actuator_now,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [31:0] rsp_drive,
   input  logic               rsp_drive_written,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int                 fail_count,
   output int                 pending_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import pidaw_pkg::*;

   typedef struct {
      logic signed [31:0] drive;
      logic               written;
   } drive_beat_type;

   drive_beat_type drive_queue[$];

   // controller copy
   longint kp, ti, td, trim, lo_clamp, hi_clamp;
   logic [1:0] wrap;
   longint integ_acc, last_meas;
   bit     restart_armed;

   function automatic longint clip(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function automatic longint qmul(longint a, longint b);
      return clip((a * b) >>> 16);
   endfunction

   // one control tick
   task automatic control_tick(longint y, longint r, longint dt, bit en, bit rq,
                               longint act);
      bit integ;
      longint err, pt, ke, dy, kd, dterm, u, o;
      drive_beat_type b;
      integ = ti > 6;
      if (dt == 0) dt = 1;
      if (rq) restart_armed = 1;
      err = clip(r - y);
      if (wrap == WrapDeg) begin
         if (err < -11796480) err = clip(err + 2 * 11796480);
         if (err > 11796480) err = clip(err - 2 * 11796480);
      end else if (wrap == WrapRad) begin
         if (err < -205887) err = clip(err + 2 * 205887);
         if (err > 205887) err = clip(err - 2 * 205887);
      end
      pt = clip(qmul(kp, err) + trim);
      if (integ) begin
         ke = qmul(kp, err);
         integ_acc = clip(integ_acc + clip((ke * dt) / ti));
      end else begin
         integ_acc = 0;
      end
      if (restart_armed) begin
         if (integ) begin
            u = act;
            if (u < lo_clamp) u = lo_clamp;
            if (u > hi_clamp) u = hi_clamp;
            integ_acc = clip(u - pt);
         end else begin
            integ_acc = 0;
         end
         restart_armed = 0;
      end
      dy = clip(y - last_meas);
      last_meas = y;
      kd = qmul(kp, td);
      dterm = clip((kd * clip(-dy)) / dt);
      o = clip(pt + integ_acc + dterm);
      if (o < lo_clamp) begin
         if (integ) integ_acc = clip(integ_acc + (lo_clamp - o));
         o = lo_clamp;
      end
      if (o > hi_clamp) begin
         if (integ) integ_acc = clip(integ_acc - (o - hi_clamp));
         o = hi_clamp;
      end
      if (!en) restart_armed = 1;
      b.drive = o[31:0];
      b.written = en;
      drive_queue.insert(drive_queue.size(), b);
   endtask

   always @(posedge clock) begin
      drive_beat_type e;
      if (reset) begin
         kp = 0; ti = 0; td = 0; trim = 0;
         lo_clamp = -64'sd2147483648; hi_clamp = 64'sd2147483647; wrap = 0;
         integ_acc = 0; last_meas = 0; restart_armed = 1;
         drive_queue.delete();
         fail_count <= 0;
      end else begin
         // register writes
         if (csr_write) begin
            case (csr_index)
               CsrKp:   kp = longint'(signed'(csr_data));
               CsrTi:   ti = longint'(csr_data[30:0]);
               CsrTd:   td = longint'(csr_data[30:0]);
               CsrTrim: trim = longint'(signed'(csr_data));
               CsrMin:  lo_clamp = longint'(signed'(csr_data));
               CsrMax:  hi_clamp = longint'(signed'(csr_data));
               CsrWrap: wrap = csr_data[1:0];
               default: ;
            endcase
         end
         // compare result beat
         if (rsp_valid && !rsp_stall) begin
            if (drive_queue.size() == 0) begin
               if (fail_count < 10) $display("unexpected result beat %0d", rsp_drive);
               fail_count <= fail_count + 1;
            end else begin
               e = drive_queue.pop_front();
               if (e.drive !== rsp_drive || e.written !== rsp_drive_written) begin
                  if (fail_count < 10)
                     $display("mismatch: exp drive %0d wr %0b, got drive %0d wr %0b",
                              e.drive, e.written, rsp_drive, rsp_drive_written);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // predict on request beat
         if (req_valid && !req_stall)
            control_tick(req_measurement, req_setpoint, req_time_step,
                         req_enable, req_restart_request, req_actuator_now);
      end
      pending_count = drive_queue.size();
   end
endmodule

FILE: sim/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pidaw_pkg::*;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_stall;
   logic signed [31:0] req_measurement = 0, req_setpoint = 0, req_actuator_now = 0;
   logic [30:0] req_time_step = 1;
   logic req_enable = 0, req_restart_request = 0;
   logic rsp_valid, rsp_stall = 0;
   logic signed [31:0] rsp_drive;
   logic rsp_drive_written;
   logic csr_write = 0;
   logic [2:0] csr_index = 0;
   logic [31:0] csr_data = 0;
   int fail_count, pending_count;
   int idle_cycles = 0;

   always #4 clock = ~clock;

   pid_antiwindup_controller_unit DUT (.*);

   pid_antiwindup_checker checker_i (.*);

   // watchdog on stalled traffic
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   // result-side stall, fresh wait per beat
   initial begin
      int w;
      forever begin
         w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
         @(negedge clock);
         rsp_stall <= (w != 0);
         if (w != 0) begin
            repeat (w) @(negedge clock);
            rsp_stall <= 0;
         end
         do @(posedge clock); while (!rsp_valid);
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] v);
      @(negedge clock);
      csr_write <= 1; csr_index <= idx; csr_data <= v;
      @(negedge clock);
      csr_write <= 0;
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (pending_count != 0) @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   // valid stays up into the next beat when no idle cycles are drawn
   task automatic send_tick(logic [31:0] y, logic [31:0] r, logic [30:0] dt,
                            bit en, bit rq, logic [31:0] act);
      int w;
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
      if (w != 0) begin
         req_valid <= 0;
         repeat (w) @(negedge clock);
      end
      req_valid <= 1; req_measurement <= y; req_setpoint <= r;
      req_time_step <= dt; req_enable <= en; req_restart_request <= rq;
      req_actuator_now <= act;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   function automatic logic [31:0] rand_val(int sel);
      case (sel)
         0: return $urandom;
         1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         2: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
         default: return $urandom_range(0, 32'h00c0_0000) - 32'h0060_0000;
      endcase
   endfunction

   task automatic random_config(int mode);
      write_reg(CsrKp, mode == 0 ? 32'h7fffffff : rand_val($urandom_range(0, 3)));
      write_reg(CsrTi, mode == 1 ? 32'd6 : (mode == 0 ? 32'h7fffffff :
                $urandom_range(7, 32'h0010_0000)));
      write_reg(CsrTd, mode == 0 ? 32'h7fffffff : $urandom_range(0, 32'h0002_0000));
      write_reg(CsrTrim, rand_val($urandom_range(0, 3)));
      if (mode == 2) begin
         write_reg(CsrMin, 32'h0001_0000); write_reg(CsrMax, 32'hffff_0000);
      end else begin
         write_reg(CsrMin, mode == 0 ? 32'h80000000 : 32'hfff0_0000 - $urandom_range(0, 32'h00100000));
         write_reg(CsrMax, mode == 0 ? 32'h7fffffff : 32'h0010_0000 + $urandom_range(0, 32'h00100000));
      end
      write_reg(CsrWrap, $urandom_range(0, 3));
   endtask

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      // directed: extremes, zero time step, threshold ti, inverted clamps
      write_reg(CsrKp, 32'h0001_0000);
      write_reg(CsrTi, 32'h0001_0000);
      write_reg(CsrTd, 32'h0000_8000);
      write_reg(CsrWrap, WrapDeg);
      send_tick(32'h7fffffff, 32'h80000000, 31'd0, 1, 0, 32'h0);
      send_tick(32'h80000000, 32'h7fffffff, 31'h7fffffff, 1, 1, 32'h7fffffff);
      send_tick(32'h00b4_0001, 32'h0, 31'd1, 0, 0, 32'h80000000);
      send_tick(32'h0, 32'h0, 31'h0001_0000, 1, 0, 32'h1234_5678);
      wait_drained();
      write_reg(CsrWrap, WrapRad);
      send_tick(32'h0003_2440, 32'h0, 31'h0000_0100, 1, 0, 32'h0);
      send_tick(32'hfffc_0000, 32'h0004_0000, 31'h0000_0100, 1, 1, 32'h0);
      wait_drained();
      write_reg(CsrWrap, 32'd3);
      write_reg(CsrTi, 32'd6);
      send_tick(32'h0001_0000, 32'h0, 31'h0000_1000, 1, 0, 32'h0);
      wait_drained();
      write_reg(CsrMin, 32'h0010_0000); write_reg(CsrMax, 32'hfff0_0000);
      write_reg(CsrTrim, 32'h8000_0000);
      send_tick(32'h0, 32'h0001_0000, 31'h0000_1000, 0, 0, 32'h0);
      send_tick(32'h0, 32'h0001_0000, 31'h0000_1000, 1, 0, 32'h0);
      wait_drained();
      // random phases
      for (int ph = 0; ph < 14; ph++) begin
         random_config(ph < 3 ? ph : 3);
         for (int i = 0; i < 50; i++) begin
            if ($urandom_range(0, 4) == 0)
               send_tick($urandom, $urandom, $urandom, $urandom_range(0, 1),
                         $urandom_range(0, 1), $urandom);
            else
               send_tick(rand_val(1), rand_val(1), $urandom_range(1, 32'h0002_0000),
                         $urandom_range(0, 9) != 0, $urandom_range(0, 9) == 0,
                         rand_val($urandom_range(0, 3)));
         end
         wait_drained();
      end
      if (fail_count == 0) $display("tb: PASS");
      else $display("tb: FAIL");
      $finish;
   end
endmodule

FILE: files.f
src/pidaw_pkg.sv
src/pidaw_div.sv
src/pidaw_datapath.sv
src/pidaw_control.sv
src/pid_antiwindup_controller_unit.sv
sim/pid_antiwindup_checker.sv
sim/tb.sv
